/* hdl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// shared widths, command and register codes, and cell constants for the
// text console character writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    // default screen geometry
    localparam int ROWS_DEF     = 24;
    localparam int MAX_COLS_DEF = 80;

    // field widths
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int COL_W      = 7;
    localparam int ROW_IN_W   = 5;
    localparam int POS_W      = 11;
    localparam int CELL_W     = 16;
    localparam int ATTR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    // cell constants
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;
    localparam logic [COL_W-1:0]  COLS_RESET   = 7'd80;
    localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;

endpackage

/* hdl/text_console_char_writer.sv */
// sequence: a printable character put passes the decode, write and position states before
//   the result register is loaded; a newline skips the write state, a read in range passes
//   the read issue and capture states, a clear sweeps every cell, and a scrolling put adds a sweep
// throughput: one item at a time; clear and scroll sweep every cell once through the
//   single write port. reset: synchronous active low; afterwards a clearing pass writes
//   0x0720 to all ROWS*MAX_COLS cells before the first item is taken
// ----------------------------------------------------------------------------
// text_console_char_writer
// text-mode console screen store with cursor, scroll, clear and cell read,
// run by a small sequencer around one shared multiply-add unit
// ----------------------------------------------------------------------------
module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter int ROWS     = ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [COL_W-1:0]      i_read_col,
    input  logic [ROW_IN_W-1:0]   i_read_row,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COL_W-1:0]      o_cursor_col,
    output logic [ROW_IN_W-1:0]   o_cursor_row,
    output logic [POS_W-1:0]      o_cursor_position,
    output logic [CELL_W-1:0]     o_cell_value,
    output logic                  o_scrolled,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // geometry derived from the parameters
    localparam int CELL_COUNT = ROWS * MAX_COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int PROD_W     = ROW_W + 9;
    localparam int COPY_N     = CELL_COUNT - MAX_COLS;

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(COPY_N);
    localparam logic [7:0]        PITCH     = 8'(MAX_COLS);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a command transfer
    localparam logic [2:0] S_EXEC  = 3'd1;  // decode, compute cell address
    localparam logic [2:0] S_WRITE = 3'd2;  // write character cell, move cursor
    localparam logic [2:0] S_RD    = 3'd3;  // issue cell read
    localparam logic [2:0] S_RDW   = 3'd4;  // capture read data
    localparam logic [2:0] S_SWEEP = 3'd5;  // walk every cell: fill or scroll copy
    localparam logic [2:0] S_DRAIN = 3'd6;  // last sweep write lands
    localparam logic [2:0] S_POS   = 3'd7;  // cursor position, load result register

    // sequencer and cursor state
    logic [2:0]        r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_scr, n_scr;
    logic [CELL_W-1:0] r_cell, n_cell;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic              r_copy, n_copy;
    logic              r_item, n_item;
    logic [CELL_W-1:0] r_fill, n_fill;

    // latched command
    logic [CMD_W-1:0]    r_cmd;
    logic [CHAR_W-1:0]   r_char;
    logic [COL_W-1:0]    r_rcol;
    logic [ROW_IN_W-1:0] r_rrow;

    // configuration registers
    logic [ATTR_W-1:0] r_attr;
    logic [COL_W-1:0]  r_cols_cfg;
    logic              r_cfg_rdy;

    // cell address from the shared unit
    logic [ADDR_W-1:0] r_addr;

    // sweep write stage (registered in the cycle after the read of the copy source)
    logic              r_s1_vld;
    logic [ADDR_W-1:0] r_s1_dst;
    logic              r_s1_copy;

    // result register
    logic                r_out_vld;
    logic [COL_W-1:0]    r_out_col;
    logic [ROW_IN_W-1:0] r_out_row;
    logic [POS_W-1:0]    r_out_pos;
    logic [CELL_W-1:0]   r_out_cell;
    logic                r_out_scr;

    logic              w_in_xfer;
    logic              w_out_load;
    logic [COL_W-1:0]  w_cols;
    logic              w_rd_ok;
    logic [31:0]       w_rrow_ext;
    logic [31:0]       w_row_ext;
    logic [31:0]       w_src_ext;
    logic              w_in_copy;
    logic [ROW_W-1:0]  w_mac_a;
    logic [7:0]        w_mac_b;
    logic [COL_W-1:0]  w_mac_c;
    logic [PROD_W-1:0] w_mac;
    logic [31:0]       w_mac_ext;
    logic [COL_W:0]    w_col_inc;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic [CELL_W-1:0] w_rdata;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == S_POS) && (!r_out_vld || i_out_ready);

    // columns in use: zero acts as one, anything past the store width is clamped
    always_comb begin
        if (r_cols_cfg == '0) begin
            w_cols = COL_W'(1);
        end else if (32'(r_cols_cfg) > MAX_COLS) begin
            w_cols = COL_W'(MAX_COLS);
        end else begin
            w_cols = r_cols_cfg;
        end
    end

    assign w_rrow_ext = 32'(r_rrow);
    assign w_row_ext  = 32'(r_row);
    assign w_rd_ok    = (r_rcol < w_cols) && (w_rrow_ext < ROWS);

    // copy source during a scroll is one row further down
    assign w_src_ext  = 32'(r_ptr) + 32'(MAX_COLS);
    assign w_in_copy  = r_copy && (r_ptr < COPY_END);

    // shared multiply-add: row * pitch + col for addresses,
    // row * columns in use + col for the reported position
    always_comb begin
        w_mac_a = r_row;
        w_mac_b = PITCH;
        w_mac_c = r_col;
        if ((r_state == S_EXEC) && (r_cmd == CMD_READ)) begin
            w_mac_a = w_rrow_ext[ROW_W-1:0];
            w_mac_c = r_rcol;
        end else if (r_state == S_POS) begin
            w_mac_b = {1'b0, w_cols};
        end
    end

    assign w_mac     = PROD_W'(w_mac_a) * PROD_W'(w_mac_b) + PROD_W'(w_mac_c);
    assign w_mac_ext = 32'(w_mac);
    assign w_col_inc = {1'b0, r_col} + 1'b1;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_scr   = r_scr;
        n_cell  = r_cell;
        n_ptr   = r_ptr;
        n_copy  = r_copy;
        n_item  = r_item;
        n_fill  = r_fill;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_EXEC;
                    n_scr   = 1'b0;
                    n_cell  = '0;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_PUT: begin
                        if (r_char == NEWLINE_CODE) begin
                            n_col = '0;
                            if (r_row == LAST_ROW) begin
                                // past the bottom: scroll, cursor stays on the last row
                                n_state = S_SWEEP;
                                n_scr   = 1'b1;
                                n_ptr   = '0;
                                n_copy  = 1'b1;
                                n_item  = 1'b1;
                                n_fill  = {r_attr, BLANK_CODE};
                            end else begin
                                n_row   = r_row + ROW_W'(1);
                                n_state = S_POS;
                            end
                        end else begin
                            n_state = S_WRITE;
                        end
                    end
                    CMD_CLEAR: begin
                        n_state = S_SWEEP;
                        n_ptr   = '0;
                        n_copy  = 1'b0;
                        n_item  = 1'b1;
                        n_fill  = {r_attr, BLANK_CODE};
                    end
                    CMD_READ: begin
                        n_state = w_rd_ok ? S_RD : S_POS;
                    end
                    default: begin
                        n_state = S_POS;
                    end
                endcase
            end
            S_WRITE: begin
                n_state = S_POS;
                if (w_col_inc >= {1'b0, w_cols}) begin
                    n_col = '0;
                    if (r_row == LAST_ROW) begin
                        n_state = S_SWEEP;
                        n_scr   = 1'b1;
                        n_ptr   = '0;
                        n_copy  = 1'b1;
                        n_item  = 1'b1;
                        n_fill  = {r_attr, BLANK_CODE};
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    n_col = w_col_inc[COL_W-1:0];
                end
            end
            S_RD: begin
                n_state = S_RDW;
            end
            S_RDW: begin
                n_cell  = w_rdata;
                n_state = S_POS;
            end
            S_SWEEP: begin
                if (r_ptr == LAST_ADDR) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                // the clearing pass after reset gives no result
                n_state = r_item ? S_POS : S_IDLE;
            end
            S_POS: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // start with the clearing pass over the whole store
            r_state    <= S_SWEEP;
            r_col      <= '0;
            r_row      <= '0;
            r_scr      <= 1'b0;
            r_cell     <= '0;
            r_ptr      <= '0;
            r_copy     <= 1'b0;
            r_item     <= 1'b0;
            r_fill     <= RESET_CELL;
            r_attr     <= ATTR_RESET;
            r_cols_cfg <= COLS_RESET;
            r_cfg_rdy  <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_scr     <= n_scr;
            r_cell    <= n_cell;
            r_ptr     <= n_ptr;
            r_copy    <= n_copy;
            r_item    <= n_item;
            r_fill    <= n_fill;
            r_cfg_rdy <= 1'b1;
            r_s1_vld  <= (r_state == S_SWEEP);

            // configuration transfer
            if (i_cfg_valid && r_cfg_rdy) begin
                case (i_cfg_index)
                    REG_ATTR: r_attr     <= i_cfg_data;
                    REG_COLS: r_cols_cfg <= i_cfg_data[COL_W-1:0];
                    default: ;
                endcase
            end

            // result register: freed by a result transfer, loaded from the sequencer
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd  <= i_command;
            r_char <= i_char_code;
            r_rcol <= i_read_col;
            r_rrow <= i_read_row;
        end
        if (r_state == S_EXEC) begin
            r_addr <= w_mac_ext[ADDR_W-1:0];
        end
        r_s1_dst  <= r_ptr;
        r_s1_copy <= w_in_copy;
        if (w_out_load) begin
            r_out_col  <= r_col;
            r_out_row  <= w_row_ext[ROW_IN_W-1:0];
            r_out_pos  <= w_mac_ext[POS_W-1:0];
            r_out_cell <= r_cell;
            r_out_scr  <= r_scr;
        end
    end

    // store ports: the character write and the sweep stage never overlap
    assign w_we    = (r_state == S_WRITE) || r_s1_vld;
    assign w_waddr = (r_state == S_WRITE) ? r_addr : r_s1_dst;
    assign w_wdata = (r_state == S_WRITE) ? {r_attr, r_char}
                                          : (r_s1_copy ? w_rdata : r_fill);
    assign w_re    = (r_state == S_RD) || ((r_state == S_SWEEP) && w_in_copy);
    assign w_raddr = (r_state == S_RD) ? r_addr : w_src_ext[ADDR_W-1:0];

    tcw_screen_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_cfg_ready       = r_cfg_rdy;
    assign o_out_valid       = r_out_vld;
    assign o_cursor_col      = r_out_col;
    assign o_cursor_row      = r_out_row;
    assign o_cursor_position = r_out_pos;
    assign o_cell_value      = r_out_cell;
    assign o_scrolled        = r_out_scr;

endmodule

/* hdl/tcw_screen_ram.sv */
// ----------------------------------------------------------------------------
// tcw_screen_ram
// screen cell store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH  = ROWS_DEF * MAX_COLS_DEF,
    parameter int ADDR_W = $clog2(ROWS_DEF * MAX_COLS_DEF)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [CELL_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks for the text console character writer
// ----------------------------------------------------------------------------
module tcw_checker
    import tcw_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [COL_W-1:0]      o_cursor_col,
    input logic [POS_W-1:0]      o_cursor_position,
    input logic [CELL_W-1:0]     o_cell_value,
    input logic                  o_scrolled
);

    // one command at a time: busy right after a command transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("command taken while previous one in progress");

    // a scroll only comes from a row advance, which puts the cursor at column zero
    a_scroll_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |-> o_cursor_col == '0)
        else $error("scroll reported with cursor off column zero");

    // reset starts the clearing pass: no result and no command acceptance
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("block active right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cursor_position)
            && $stable(o_cell_value) && $stable(o_scrolled))
        else $error("result changed while stalled");

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_cursor_col      (o_cursor_col),
    .o_cursor_position (o_cursor_position),
    .o_cell_value      (o_cell_value),
    .o_scrolled        (o_scrolled)
);
